FILE: rtl/core/dda_pkg.sv
// Shared types and constants of the decimal digit accumulator.
package dda_pkg;

	// Action codes carried in the input tuser.
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_ADD   = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// Display modes for reads.
	localparam logic [1:0] MODE_PLAIN = 2'd0;
	localparam logic [1:0] MODE_SKIP  = 2'd1;
	localparam logic [1:0] MODE_BLANK = 2'd2;

	// Field widths and positions.
	localparam int ADDEND_W  = 32;
	localparam int COUNT_W   = 16;
	localparam int MODE_W    = 2;
	localparam int ACTION_W  = 2;
	localparam int PROD_W    = ADDEND_W + COUNT_W;
	localparam int VALUE_W   = 52;
	localparam int POS_W     = 4;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 64;
	localparam int ADDEND_LSB = 0;
	localparam int COUNT_LSB  = ADDEND_LSB + ADDEND_W;
	localparam int MODE_LSB   = COUNT_LSB + COUNT_W;

	// Wide enough for the conversion bit count and for a digit count of up to 64.
	localparam int CNT_W = 6;

	typedef enum logic [2:0] {
		KIND_CLEAR,
		KIND_ADD,
		KIND_READ_PLAIN,
		KIND_READ_SKIP,
		KIND_READ_BLANK
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [PROD_W-1:0]  product;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_ADD,
		ST_OUT
	} back_state_t;

endpackage

FILE: rtl/core/decimal_digit_accumulator_core.sv
// Top level of the decimal digit accumulator.
//
// Input channel s_*: s_tuser carries the action (clear, add, read) and s_tdata the
// addend, repeat count and display mode. Every input transfer yields exactly one
// result transfer on m_*: packed BCD value, blanked digit count and start position.
// A front stage takes the transfer and forms the 48-bit product of addend and
// repeat count; a two-entry command queue feeds the back end, which holds the
// digits. Clears and reads finish in the back end at once: the front stage, the queue
// and the result register lie between acceptance and result, and one item per cycle
// can flow while m_tready is high and no add is running. An add with a nonzero count
// runs a bit-serial binary-to-BCD conversion of the product and then a digit-serial
// decimal add; the back end takes no new command until the sum is in the result register.
// The result register parts the two sides: a stalled m_tready holds the result
// while the queue keeps taking new transfers until it is full, and only then does
// s_tready drop. Reset clears all digits, the blank count and every valid flag.
module decimal_digit_accumulator_core #(
	parameter int DIGITS = 13
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// Bits from low: addend[31:0], repeat_count[47:32], display_mode[49:48], zero fill.
	input  logic [55:0] s_tdata,
	// Bits from low: action[1:0].
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// Bits from low: value_bcd[51:0], blanked_count[55:52], start_position[59:56],
	// zero fill.
	output logic [63:0] m_tdata
);

	// The queue only has to cover the front stage while the back end is busy.
	localparam int CMD_DEPTH = 2;

	dda_pkg::cmd_t front_cmd;
	logic          front_valid;
	logic          front_ready;
	dda_pkg::cmd_t queue_cmd;
	logic          queue_valid;
	logic          queue_pop;

	dda_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (front_cmd),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready)
	);

	dda_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_cmd    (front_cmd),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.out_cmd   (queue_cmd),
		.out_valid (queue_valid),
		.out_pop   (queue_pop)
	);

	// The back end owns the digit store and the result register.
	dda_back #(
		.DIGITS (DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (queue_cmd),
		.cmd_valid (queue_valid),
		.cmd_pop   (queue_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

FILE: rtl/core/dda_front.sv
// Front end: accepts input transfers, classifies them and forms the addend product.
module dda_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [dda_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic [dda_pkg::ACTION_W-1:0]        s_tuser,
	output dda_pkg::cmd_t                       cmd,
	output logic                                cmd_valid,
	input  logic                                cmd_ready
);

	logic [dda_pkg::ADDEND_W-1:0] addend;
	logic [dda_pkg::COUNT_W-1:0]  count;
	logic [dda_pkg::MODE_W-1:0]   mode;
	dda_pkg::kind_t               kind;
	dda_pkg::cmd_t                cmd_s1;
	logic                         valid_s1;

	assign addend = s_tdata[dda_pkg::ADDEND_LSB +: dda_pkg::ADDEND_W];
	assign count  = s_tdata[dda_pkg::COUNT_LSB +: dda_pkg::COUNT_W];
	assign mode   = s_tdata[dda_pkg::MODE_LSB +: dda_pkg::MODE_W];

	assign s_tready = !valid_s1 || cmd_ready;

	// An add with a zero count leaves the state alone and behaves as a plain read.
	always_comb begin
		case (s_tuser)
			dda_pkg::ACT_CLEAR: kind = dda_pkg::KIND_CLEAR;
			dda_pkg::ACT_ADD: begin
				kind = (count != '0) ? dda_pkg::KIND_ADD : dda_pkg::KIND_READ_PLAIN;
			end
			dda_pkg::ACT_READ: begin
				case (mode)
					dda_pkg::MODE_SKIP:  kind = dda_pkg::KIND_READ_SKIP;
					dda_pkg::MODE_BLANK: kind = dda_pkg::KIND_READ_BLANK;
					default:             kind = dda_pkg::KIND_READ_PLAIN;
				endcase
			end
			default: kind = dda_pkg::KIND_READ_PLAIN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1.kind    <= kind;
			cmd_s1.product <= dda_pkg::PROD_W'(addend) * dda_pkg::PROD_W'(count);
		end
	end

	assign cmd       = cmd_s1;
	assign cmd_valid = valid_s1;

endmodule

FILE: rtl/core/dda_cmd_fifo.sv
// Short command queue between the front end and the back end.
module dda_cmd_fifo #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  dda_pkg::cmd_t  in_cmd,
	input  logic           in_valid,
	output logic           in_ready,
	output dda_pkg::cmd_t  out_cmd,
	output logic           out_valid,
	input  logic           out_pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	dda_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic             push;
	logic             pop;

	assign in_ready  = fill_q != FILL_W'(DEPTH);
	assign out_valid = fill_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_pop && out_valid;
	assign out_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

FILE: rtl/core/dda_back.sv
// Back end: digit store, bit-serial BCD conversion, digit-serial add and result register.
module dda_back #(
	parameter int DIGITS = 13
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dda_pkg::cmd_t                    cmd,
	input  logic                             cmd_valid,
	output logic                             cmd_pop,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [dda_pkg::OUT_DATA_W-1:0]   m_tdata
);

	localparam int W = DIGITS * 4;

	dda_pkg::back_state_t state_q;
	dda_pkg::back_state_t state_d;

	logic [W-1:0]                acc_q;
	logic [W-1:0]                bcd_q;
	logic [dda_pkg::PROD_W-1:0]  prod_q;
	logic [dda_pkg::CNT_W-1:0]   cnt_q;
	logic                        carry_q;
	logic [dda_pkg::POS_W-1:0]   blank_q;

	logic                        out_valid_q;
	logic [dda_pkg::VALUE_W-1:0] out_value_q;
	logic [dda_pkg::POS_W-1:0]   out_blank_q;
	logic [dda_pkg::POS_W-1:0]   out_start_q;

	logic out_free;
	logic conv_last;
	logic add_last;
	logic start_add;
	logic conv_en;
	logic add_en;
	logic load_imm;
	logic load_add;

	logic [W-1:0]              dab;
	logic [W-1:0]              dab_next;
	logic [4:0]                dsum;
	logic [3:0]                dsum_digit;
	logic                      dsum_carry;
	logic [W-1:0]              acc_shift;
	logic [4:0]                lz;
	logic [dda_pkg::POS_W-1:0] lz_sat;
	logic [W-1:0]              imm_acc;
	logic [dda_pkg::POS_W-1:0] imm_blank;
	logic [dda_pkg::POS_W-1:0] imm_start;
	logic [dda_pkg::OUT_DATA_W-1:0] imm_wide;
	logic [dda_pkg::OUT_DATA_W-1:0] acc_wide;

	assign out_free  = !out_valid_q || m_tready;
	assign conv_last = cnt_q == dda_pkg::CNT_W'(dda_pkg::PROD_W - 1);
	assign add_last  = cnt_q == dda_pkg::CNT_W'(DIGITS - 1);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			dda_pkg::ST_IDLE: begin
				if (cmd_valid && cmd.kind == dda_pkg::KIND_ADD) begin
					state_d = dda_pkg::ST_CONV;
				end
			end
			dda_pkg::ST_CONV: begin
				if (conv_last) begin
					state_d = dda_pkg::ST_ADD;
				end
			end
			dda_pkg::ST_ADD: begin
				if (add_last) begin
					state_d = dda_pkg::ST_OUT;
				end
			end
			dda_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = dda_pkg::ST_IDLE;
				end
			end
			default: state_d = dda_pkg::ST_IDLE;
		endcase
	end

	// Control strobes.
	always_comb begin
		cmd_pop   = 1'b0;
		start_add = 1'b0;
		conv_en   = 1'b0;
		add_en    = 1'b0;
		load_imm  = 1'b0;
		load_add  = 1'b0;
		case (state_q)
			dda_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.kind == dda_pkg::KIND_ADD) begin
						cmd_pop   = 1'b1;
						start_add = 1'b1;
					end else if (out_free) begin
						cmd_pop  = 1'b1;
						load_imm = 1'b1;
					end
				end
			end
			dda_pkg::ST_CONV: conv_en  = 1'b1;
			dda_pkg::ST_ADD:  add_en   = 1'b1;
			dda_pkg::ST_OUT:  load_add = out_free;
			default: ;
		endcase
	end

	// One double-dabble step: correct digits of five or more, then shift in a product bit.
	always_comb begin
		dab = bcd_q;
		for (int d = 0; d < DIGITS; d++) begin
			if (dab[d*4 +: 4] >= 4'd5) begin
				dab[d*4 +: 4] = dab[d*4 +: 4] + 4'd3;
			end
		end
		dab_next = (dab << 1) | W'(prod_q[dda_pkg::PROD_W-1]);
	end

	// One decimal digit of the accumulator sum; the store rotates right by a digit.
	always_comb begin
		dsum = {1'b0, acc_q[3:0]} + {1'b0, bcd_q[3:0]} + {4'b0, carry_q};
		if (dsum >= 5'd10) begin
			dsum_digit = 4'(dsum - 5'd10);
			dsum_carry = 1'b1;
		end else begin
			dsum_digit = dsum[3:0];
			dsum_carry = 1'b0;
		end
		acc_shift = acc_q >> 4;
		acc_shift[W-1 -: 4] = dsum_digit;
	end

	// Leading zero digits: the highest nonzero digit wins.
	always_comb begin
		lz = 5'(DIGITS);
		for (int i = 0; i < DIGITS; i++) begin
			if (acc_q[i*4 +: 4] != 4'd0) begin
				lz = 5'(DIGITS - 1 - i);
			end
		end
		lz_sat = (lz > 5'd15) ? 4'd15 : lz[3:0];
	end

	// Results of items that finish at once.
	always_comb begin
		imm_acc   = acc_q;
		imm_blank = blank_q;
		imm_start = '0;
		case (cmd.kind)
			dda_pkg::KIND_CLEAR: begin
				imm_acc   = '0;
				imm_blank = '0;
			end
			dda_pkg::KIND_READ_SKIP:  imm_start = lz_sat;
			dda_pkg::KIND_READ_BLANK: imm_blank = lz_sat;
			default: ;
		endcase
		imm_wide = dda_pkg::OUT_DATA_W'(imm_acc);
		acc_wide = dda_pkg::OUT_DATA_W'(acc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dda_pkg::ST_IDLE;
			acc_q       <= '0;
			blank_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_imm) begin
				acc_q   <= imm_acc;
				blank_q <= imm_blank;
			end else if (add_en) begin
				acc_q <= acc_shift;
			end else if (load_add) begin
				blank_q <= '0;
			end
			if (load_imm || load_add) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_add) begin
			prod_q  <= cmd.product;
			bcd_q   <= '0;
			cnt_q   <= '0;
			carry_q <= 1'b0;
		end else if (conv_en) begin
			bcd_q  <= dab_next;
			prod_q <= prod_q << 1;
			cnt_q  <= conv_last ? '0 : cnt_q + 1'b1;
		end else if (add_en) begin
			bcd_q   <= bcd_q >> 4;
			carry_q <= dsum_carry;
			cnt_q   <= cnt_q + 1'b1;
		end
		if (load_imm) begin
			out_value_q <= imm_wide[dda_pkg::VALUE_W-1:0];
			out_blank_q <= imm_blank;
			out_start_q <= imm_start;
		end else if (load_add) begin
			out_value_q <= acc_wide[dda_pkg::VALUE_W-1:0];
			out_blank_q <= '0;
			out_start_q <= '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_start_q, out_blank_q, out_value_q};

endmodule
